### hdl/shli_pkg.sv
`default_nettype none

package shli_pkg;

    localparam int KEY_W  = 32;
    localparam int LOC_W  = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam logic [LOC_W-1:0] BAD_LOCATION = 32'hFFFF_FFFF;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_LOAD   = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND  = 2'd0,
        ST_ABSENT = 2'd1,
        ST_ACCEPT = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_ABSENT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

### hdl/shli_ifs.sv
`default_nettype none

interface shli_in_if;
    logic                                valid;
    logic                                ready;
    logic [shli_pkg::FUNC_W-1:0]         func;
    logic [shli_pkg::KEY_W-1:0]          key_hash;
    logic [shli_pkg::LOC_W-1:0]          record_location;

    modport source (output valid, func, key_hash, record_location, input ready);
    modport sink   (input valid, func, key_hash, record_location, output ready);
endinterface

interface shli_out_if;
    logic                                valid;
    logic                                ready;
    logic [shli_pkg::STAT_W-1:0]         status;
    logic [shli_pkg::LOC_W-1:0]          found_location;
    logic                                last;

    modport source (output valid, status, found_location, last, input ready);
    modport sink   (input valid, status, found_location, last, output ready);
endinterface

`default_nettype wire

### hdl/shli_ram.sv
`default_nettype none

module shli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/sorted_hash_location_index_top.sv
`default_nettype none

// Channel  Dir  Payload                                   Notes
// req      in   func, key_hash, record_location          clear / load / lookup
// rsp      out  status, found_location, last             one or more per transaction, none for unused func
//
// Clear and load: the acknowledgement is written to the output register on acceptance.
// Lookup: accept, then one entry-RAM probe per cycle of the binary search
//   (at most ceil(log2(entries+1)) probes, 11 at 1024 entries), one check read,
//   then one location of the group per cycle through the location RAM while rsp is not stalled.
// req.ready is high only in idle and while the output register is free or
//   being drained; a stalled rsp holds the sequencer in place.
// Reset clears the counters, the FSM and the output valid only; the RAMs need no clearing pass.

module sorted_hash_location_index_top #(
    parameter int ENTRY_DEPTH    = 1024,
    parameter int LOCATION_DEPTH = 4096,
    parameter int MAX_GROUP      = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    shli_in_if.sink        req,
    shli_out_if.source     rsp
);

    // Index / count widths. Counts need one more state than indexes (full).
    localparam int EW  = $clog2(ENTRY_DEPTH);
    localparam int EC  = $clog2(ENTRY_DEPTH + 1);
    localparam int LW  = $clog2(LOCATION_DEPTH);
    localparam int LC  = $clog2(LOCATION_DEPTH + 1);
    localparam int GW  = $clog2(MAX_GROUP + 1);
    localparam int KW  = shli_pkg::KEY_W;
    localparam int LOW = shli_pkg::LOC_W;
    // Entry word: {hash, first slot, group size}
    localparam int E_W = KW + LW + GW;

    // Control state
    shli_pkg::state_t   state_reg, state_next;
    logic [EC-1:0]      entries_reg, entries_next;
    logic [LC-1:0]      slots_reg, slots_next;
    logic               out_valid_reg, out_valid_next;

    // Payload / datapath registers
    logic [KW-1:0]      top_hash_reg, top_hash_next;
    logic [LW-1:0]      top_first_reg, top_first_next;
    logic [GW-1:0]      top_size_reg, top_size_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [EC-1:0]      lo_reg, lo_next;
    logic [EC-1:0]      hi_reg, hi_next;
    logic [LW-1:0]      slot_reg, slot_next;
    logic [GW-1:0]      left_reg, left_next;
    shli_pkg::status_t  out_status_reg, out_status_next;
    logic [LOW-1:0]     out_loc_reg, out_loc_next;
    logic               out_last_reg, out_last_next;

    // RAM ports
    logic               ent_we;
    logic [EW-1:0]      ent_waddr, ent_raddr;
    logic [E_W-1:0]     ent_wdata, ent_rdata;
    logic               loc_we;
    logic [LW-1:0]      loc_waddr, loc_raddr;
    logic [LOW-1:0]     loc_wdata, loc_rdata;

    // Shared search step
    logic [KW-1:0]      rd_hash;
    logic [LW-1:0]      rd_first;
    logic [GW-1:0]      rd_size;
    logic [EC-1:0]      mid_cur, step_lo, step_hi, step_mid, mid0, top_idx;

    // Load decision
    logic               out_space, accept, has_top, is_append, ld_reject;

    shli_ram #(.WIDTH(E_W), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    shli_ram #(.WIDTH(LOW), .DEPTH(LOCATION_DEPTH)) u_loc_ram (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (loc_raddr),
        .rdata (loc_rdata)
    );

    assign out_space = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == shli_pkg::S_IDLE) && out_space;
    assign accept    = req.valid && req.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_location = out_loc_reg;
    assign rsp.last           = out_last_reg;

    assign rd_hash  = ent_rdata[E_W-1 -: KW];
    assign rd_first = ent_rdata[LW+GW-1 -: LW];
    assign rd_size  = ent_rdata[GW-1:0];

    // One binary-search step on the entry just read (entry at mid_cur)
    assign mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign step_lo  = (rd_hash < key_reg) ? mid_cur + EC'(1) : lo_reg;
    assign step_hi  = (rd_hash < key_reg) ? hi_reg : mid_cur;
    assign step_mid = step_lo + ((step_hi - step_lo) >> 1);
    assign mid0     = entries_reg >> 1;
    assign top_idx  = entries_reg - EC'(1);

    // Newest entry is held in registers so a load never waits on a RAM read
    assign has_top   = (entries_reg != '0);
    assign is_append = has_top && (req.key_hash == top_hash_reg);
    assign ld_reject = (req.record_location == shli_pkg::BAD_LOCATION)
                    || (slots_reg == LC'(LOCATION_DEPTH))
                    || (has_top && (req.key_hash < top_hash_reg))
                    || (is_append && (top_size_reg >= GW'(MAX_GROUP)))
                    || (!is_append && (entries_reg == EC'(ENTRY_DEPTH)));

    always_comb
    begin
        state_next      = state_reg;
        entries_next    = entries_reg;
        slots_next      = slots_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        top_hash_next   = top_hash_reg;
        top_first_next  = top_first_reg;
        top_size_next   = top_size_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        slot_next       = slot_reg;
        left_next       = left_reg;
        out_status_next = out_status_reg;
        out_loc_next    = out_loc_reg;
        out_last_next   = out_last_reg;
        ent_we          = 1'b0;
        ent_waddr       = entries_reg[EW-1:0];
        ent_wdata       = {req.key_hash, slots_reg[LW-1:0], GW'(1)};
        ent_raddr       = mid0[EW-1:0];
        loc_we          = 1'b0;
        loc_waddr       = slots_reg[LW-1:0];
        loc_wdata       = req.record_location;

        unique case (state_reg)
            shli_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (shli_pkg::func_t'(req.func))
                        shli_pkg::FN_CLEAR:
                        begin
                            entries_next    = '0;
                            slots_next      = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = shli_pkg::ST_ACCEPT;
                            out_loc_next    = '0;
                            out_last_next   = 1'b1;
                        end
                        shli_pkg::FN_LOAD:
                        begin
                            out_valid_next  = 1'b1;
                            out_loc_next    = '0;
                            out_last_next   = 1'b1;
                            if (ld_reject)
                            begin
                                out_status_next = shli_pkg::ST_REJECT;
                            end
                            else
                            begin
                                out_status_next = shli_pkg::ST_ACCEPT;
                                loc_we          = 1'b1;
                                slots_next      = slots_reg + LC'(1);
                                ent_we          = 1'b1;
                                if (is_append)
                                begin
                                    ent_waddr     = top_idx[EW-1:0];
                                    ent_wdata     = {top_hash_reg, top_first_reg,
                                                     top_size_reg + GW'(1)};
                                    top_size_next = top_size_reg + GW'(1);
                                end
                                else
                                begin
                                    top_hash_next  = req.key_hash;
                                    top_first_next = slots_reg[LW-1:0];
                                    top_size_next  = GW'(1);
                                    entries_next   = entries_reg + EC'(1);
                                end
                            end
                        end
                        shli_pkg::FN_LOOKUP:
                        begin
                            key_next = req.key_hash;
                            if (!has_top)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = shli_pkg::ST_ABSENT;
                                out_loc_next    = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = entries_reg;
                                state_next = shli_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            shli_pkg::S_SEARCH:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi)
                begin
                    ent_raddr = step_mid[EW-1:0];
                end
                else if (step_lo >= entries_reg)
                begin
                    state_next = shli_pkg::S_ABSENT;
                end
                else
                begin
                    ent_raddr  = step_lo[EW-1:0];
                    state_next = shli_pkg::S_CHECK;
                end
            end

            shli_pkg::S_CHECK:
            begin
                if (rd_hash == key_reg)
                begin
                    slot_next  = rd_first;
                    left_next  = rd_size;
                    state_next = shli_pkg::S_EMIT;
                end
                else
                begin
                    state_next = shli_pkg::S_ABSENT;
                end
            end

            shli_pkg::S_ABSENT:
            begin
                if (out_space)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = shli_pkg::ST_ABSENT;
                    out_loc_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = shli_pkg::S_IDLE;
                end
            end

            shli_pkg::S_EMIT:
            begin
                if (out_space)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = shli_pkg::ST_FOUND;
                    out_loc_next    = loc_rdata;
                    out_last_next   = (left_reg == GW'(1));
                    slot_next       = slot_reg + LW'(1);
                    left_next       = left_reg - GW'(1);
                    if (left_reg == GW'(1))
                    begin
                        state_next = shli_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = shli_pkg::S_IDLE;
            end
        endcase

        // Location read follows the slot pointer so data is ready next cycle
        loc_raddr = slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shli_pkg::S_IDLE;
            entries_reg   <= '0;
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            slots_reg     <= slots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_hash_reg   <= top_hash_next;
        top_first_reg  <= top_first_next;
        top_size_reg   <= top_size_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        slot_reg       <= slot_next;
        left_reg       <= left_next;
        out_status_reg <= out_status_next;
        out_loc_reg    <= out_loc_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the sorted hash location index.
//
// One initial block runs the test tasks in turn. Every task pushes its
// transactions through send_item, which waits for the req handshake and then
// runs the index predictor on the accepted transaction. The predictor keeps
// its own copy of the entry and location stores and queues the results it
// expects. A separate process pops that queue for every rsp transaction and
// compares status, location and last field by field.

module tb_top;

    localparam int ENTRY_DEPTH    = 1024;
    localparam int LOCATION_DEPTH = 4096;
    localparam int MAX_GROUP      = 64;
    localparam int RANDOM_ITEMS   = 80;
    // Watchdog limit; leave lots of room over the slowest honest run.
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        shli_pkg::status_t          status;
        logic [shli_pkg::LOC_W-1:0] location;
        logic                       last;
    } index_result_t;

    logic clk;
    logic rst_n;

    shli_in_if  req_ch ();
    shli_out_if rsp_ch ();

    sorted_hash_location_index_top #(
        .ENTRY_DEPTH    (ENTRY_DEPTH),
        .LOCATION_DEPTH (LOCATION_DEPTH),
        .MAX_GROUP      (MAX_GROUP)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predictor state: the index as the block should hold it.
    logic [shli_pkg::KEY_W-1:0] ent_hash  [ENTRY_DEPTH];
    logic [11:0]                ent_first [ENTRY_DEPTH];
    logic [6:0]                 ent_size  [ENTRY_DEPTH];
    logic [shli_pkg::LOC_W-1:0] loc_mem   [LOCATION_DEPTH];
    logic [10:0]                n_entries;
    logic [12:0]                n_slots;

    index_result_t pending_results [$];
    index_result_t want;
    int            mismatches;
    int            cycles;
    // When set, neither side idles: the long stretch without gaps.
    bit            steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sink side: outside the steady stretch, ready is dropped with a chance of about 28 in 100.
    always @(posedge clk)
    begin
        rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    task automatic push_result(shli_pkg::status_t st, logic [shli_pkg::LOC_W-1:0] loc,
                               logic fin);
        index_result_t r;
        r.status   = st;
        r.location = loc;
        r.last     = fin;
        pending_results.push_back(r);
    endtask

    // Works out the results of one accepted transaction and updates the
    // predicted index.
    task automatic index_predict(shli_pkg::func_t f, logic [shli_pkg::KEY_W-1:0] h,
                                 logic [shli_pkg::LOC_W-1:0] l);
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        int unsigned       top;
        int unsigned       first;
        int unsigned       size;
        shli_pkg::status_t st;
        case (f)
            shli_pkg::FN_CLEAR:
            begin
                n_entries = '0;
                n_slots   = '0;
                push_result(shli_pkg::ST_ACCEPT, '0, 1'b1);
            end
            shli_pkg::FN_LOAD:
            begin
                st  = shli_pkg::ST_ACCEPT;
                top = (n_entries > 0) ? n_entries - 1 : 0;
                if (l == shli_pkg::BAD_LOCATION || n_slots >= LOCATION_DEPTH)
                    st = shli_pkg::ST_REJECT;
                else if (n_entries > 0 && h < ent_hash[top])
                    st = shli_pkg::ST_REJECT;
                else if (n_entries > 0 && h == ent_hash[top])
                begin
                    // same hash as the newest entry: append to its group
                    if (ent_size[top] >= MAX_GROUP)
                        st = shli_pkg::ST_REJECT;
                    else
                    begin
                        loc_mem[n_slots] = l;
                        n_slots          = n_slots + 13'd1;
                        ent_size[top]    = ent_size[top] + 7'd1;
                    end
                end
                else if (n_entries >= ENTRY_DEPTH)
                    st = shli_pkg::ST_REJECT;
                else
                begin
                    ent_hash[n_entries]  = h;
                    ent_first[n_entries] = n_slots[11:0];
                    ent_size[n_entries]  = 7'd1;
                    loc_mem[n_slots]     = l;
                    n_entries            = n_entries + 11'd1;
                    n_slots              = n_slots + 13'd1;
                end
                push_result(st, '0, 1'b1);
            end
            shli_pkg::FN_LOOKUP:
            begin
                lo = 0;
                hi = n_entries;
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (ent_hash[mid] < h)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo >= n_entries || ent_hash[lo] != h)
                    push_result(shli_pkg::ST_ABSENT, '0, 1'b1);
                else
                begin
                    first = ent_first[lo];
                    size  = ent_size[lo];
                    for (int unsigned i = 0; i < size; i++)
                        push_result(shli_pkg::ST_FOUND, loc_mem[first + i], (i + 1 == size));
                end
            end
            default: ;  // unused code: no result, no change
        endcase
    endtask

    // Result checker: every rsp transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: expected nothing, %s %0d %h %0d",
                         $time, "actual status/location/last", rsp_ch.status,
                         rsp_ch.found_location, rsp_ch.last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status: expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.found_location !== want.location)
                begin
                    $display("%0t: found_location: expected %h actual %h",
                             $time, want.location, rsp_ch.found_location);
                    mismatches++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $display("%0t: last: expected %0d actual %0d",
                             $time, want.last, rsp_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Source side. Any idle cycles come first with valid low; the transaction is
    // then held until ready is seen at a rising edge. A valid that stays high
    // for the next transaction is never lowered in the same step.
    task automatic send_item(shli_pkg::func_t f, logic [shli_pkg::KEY_W-1:0] h,
                             logic [shli_pkg::LOC_W-1:0] l);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.func            <= f;
        req_ch.key_hash        <= h;
        req_ch.record_location <= l;
        do
            @(posedge clk);
        while (!req_ch.ready);
        index_predict(f, h, l);
    endtask

    // Hold the sender off until every expected result is in.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Extremes of every field, each function, and the named special cases.
    task automatic test_directed();
        send_item(shli_pkg::FN_LOOKUP, 32'h0000_0000, 32'h0);        // empty index
        send_item(shli_pkg::FN_NONE,   $urandom, $urandom);           // unused code
        send_item(shli_pkg::FN_CLEAR,  32'h0, 32'h0);
        send_item(shli_pkg::FN_LOAD,   32'h0000_0000, 32'h0000_0000);
        send_item(shli_pkg::FN_LOAD,   32'h0000_0000, 32'hFFFF_FFFE);
        send_item(shli_pkg::FN_LOAD,   32'h0000_0000, shli_pkg::BAD_LOCATION);
        send_item(shli_pkg::FN_LOAD,   32'h0000_0010, 32'h1234_5678);
        send_item(shli_pkg::FN_LOAD,   32'h0000_0008, 32'h0000_0001); // out of order
        send_item(shli_pkg::FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(shli_pkg::FN_LOOKUP, 32'h0000_0010, 32'h0);
        send_item(shli_pkg::FN_LOOKUP, 32'h0000_0008, 32'h0);
        send_item(shli_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(shli_pkg::FN_LOAD,   32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_item(shli_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(shli_pkg::FN_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(shli_pkg::FN_LOAD,   32'hFFFF_FFFE, 32'h5555_5555); // out of order
        send_item(shli_pkg::FN_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(shli_pkg::FN_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(shli_pkg::FN_LOAD,   32'h8000_0000, 32'h5555_5555);
        send_item(shli_pkg::FN_LOOKUP, 32'h8000_0000, 32'h0);
        send_item(shli_pkg::FN_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        drain_results();
    endtask

    // A group filled to the brim; the next append must bounce.
    task automatic test_group_overflow();
        logic [shli_pkg::KEY_W-1:0] h;
        h = $urandom;
        if (h == 32'hFFFF_FFFF)
            h = 32'hFFFF_FFFE;
        send_item(shli_pkg::FN_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i <= MAX_GROUP; i++)
            send_item(shli_pkg::FN_LOAD, h, $urandom_range(0, 32'hFFFF_FFFE));
        send_item(shli_pkg::FN_LOAD, h + 1, $urandom_range(0, 32'hFFFF_FFFE));
        send_item(shli_pkg::FN_LOOKUP, h, 32'h0);
        send_item(shli_pkg::FN_LOOKUP, h + 1, 32'h0);
        drain_results();
    endtask

    // Mostly well-formed ascending load runs with lookups of what was loaded,
    // plus a share of noise: stray lookups, out-of-order and invalid loads,
    // unused codes and clears.
    task automatic test_random();
        int unsigned                sent;
        int unsigned                r;
        int unsigned                idx;
        logic [shli_pkg::KEY_W-1:0] base;
        logic [shli_pkg::KEY_W-1:0] top_hash;
        logic [shli_pkg::KEY_W:0]   next;
        logic [shli_pkg::KEY_W-1:0] h;
        sent = 0;
        base = $urandom_range(0, 1000);
        send_item(shli_pkg::FN_CLEAR, $urandom, $urandom);
        while (sent < RANDOM_ITEMS)
        begin
            steady   = (sent >= 35 && sent < 70);
            top_hash = (n_entries > 0) ? ent_hash[n_entries-1] : base;
            r        = $urandom_range(0, 99);
            if (sent == 30 || $urandom_range(0, 99) < 3)
                drain_results();
            if (r < 4)
            begin
                case ($urandom_range(0, 3))
                    0:       base = $urandom;
                    1:       base = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    default: base = $urandom_range(0, 1000);
                endcase
                send_item(shli_pkg::FN_CLEAR, $urandom, $urandom);
                sent++;
            end
            else if (r < 50)
            begin
                if (n_entries == 0)
                    h = base;
                else if ($urandom_range(0, 99) < 40)
                    h = top_hash;
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        next = {1'b0, top_hash} + $urandom_range(1, 32'h0100_0000);
                    else
                        next = {1'b0, top_hash} + $urandom_range(1, 8);
                    h = next[shli_pkg::KEY_W] ? top_hash : next[shli_pkg::KEY_W-1:0];
                end
                send_item(shli_pkg::FN_LOAD, h, $urandom);
                sent++;
            end
            else if (r < 80)
            begin
                if (n_entries > 0)
                begin
                    idx = $urandom_range(0, n_entries - 1);
                    h   = ent_hash[idx];
                end
                else
                    h = $urandom;
                send_item(shli_pkg::FN_LOOKUP, h, $urandom);
                sent++;
            end
            else if (r < 86)
            begin
                if (n_entries > 0 && $urandom_range(0, 1) == 0)
                begin
                    idx = $urandom_range(0, n_entries - 1);
                    h   = $urandom_range(0, 1) ? ent_hash[idx] + 1 : ent_hash[idx] - 1;
                end
                else
                    h = $urandom;
                send_item(shli_pkg::FN_LOOKUP, h, $urandom);
                sent++;
            end
            else if (r < 91)
            begin
                h = (top_hash > 0) ? $urandom_range(0, top_hash - 1) : $urandom;
                send_item(shli_pkg::FN_LOAD, h, $urandom);
                sent++;
            end
            else if (r < 94)
            begin
                send_item(shli_pkg::FN_LOAD, top_hash, shli_pkg::BAD_LOCATION);
                sent++;
            end
            else if (r < 97)
                send_item(shli_pkg::FN_NONE, $urandom, $urandom);  // ignored, not counted
            else
            begin
                send_item(shli_pkg::FN_LOAD, $urandom, $urandom);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        mismatches             = 0;
        cycles                 = 0;
        n_entries              = '0;
        n_slots                = '0;
        req_ch.valid           = 1'b0;
        req_ch.func            = shli_pkg::FN_NONE;
        req_ch.key_hash        = '0;
        req_ch.record_location = '0;
        rsp_ch.ready           = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_group_overflow();
        test_random();

        // All stimulus in: wait for the last results, then a short tail so
        // that stray extra transactions get caught.
        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hdl/shli_pkg.sv
hdl/shli_ifs.sv
hdl/shli_ram.sv
hdl/sorted_hash_location_index_top.sv
tb/tb_top.sv
